### src/cpid_pkg.sv
// ----------------------------------------------------------------------------
// cpid_pkg
// Shared types, register indexes and a helper function of the clamped PID
// controller.
// ----------------------------------------------------------------------------
package cpid_pkg;

    localparam int DERIV_OUT_LIMIT_DEF = 16384;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_OUT_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_OUT_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_OUT_LIMIT = 3'd7;

    // Integration step of 0.002 in Q0.16.
    localparam logic signed [16:0] ERR_STEP_Q16 = 17'sd131;

    typedef struct packed {
        logic               command;
        logic signed [15:0] error_in;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] drive;
        logic signed [15:0] prop_term;
        logic signed [15:0] integ_term;
        logic signed [15:0] deriv_term;
    } t_out_word;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] deriv_gain;
        logic [14:0] error_limit;
        logic [30:0] integral_limit;
        logic [14:0] prop_out_limit;
        logic [14:0] integ_out_limit;
        logic [14:0] total_out_limit;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_STEP,
        ST_ACC,
        ST_PROP,
        ST_IHI,
        ST_ILO,
        ST_DERIV,
        ST_SUM
    } t_state;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_HOLD,
        OP_ERR,
        OP_STEP,
        OP_ACC,
        OP_PROP,
        OP_IHI,
        OP_ILO,
        OP_DERIV,
        OP_SUM
    } t_dp_op;

    typedef enum logic [2:0] {
        MUL_STEP,
        MUL_PROP,
        MUL_IHI,
        MUL_ILO,
        MUL_DERIV
    } t_mul_sel;

    typedef struct packed {
        t_dp_op   op;
        t_mul_sel mul_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic clear;
        logic out_free;
    } t_dp_status;

    // Symmetric clamp of a signed value to +/-lim.
    function automatic logic signed [33:0] f_clamp(logic signed [33:0] v, logic [30:0] lim);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = signed'({3'b000, lim});
        lo = -hi;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

### src/cpid_regs.sv
// ----------------------------------------------------------------------------
// cpid_regs
// Configuration register file: gains and clamp limits, written one at a time.
// ----------------------------------------------------------------------------
module cpid_regs
    import cpid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain       <= '0;
            r_cfg.integ_gain      <= '0;
            r_cfg.deriv_gain      <= '0;
            r_cfg.error_limit     <= '1;
            r_cfg.integral_limit  <= '1;
            r_cfg.prop_out_limit  <= '1;
            r_cfg.integ_out_limit <= '1;
            r_cfg.total_out_limit <= '1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_PROP_GAIN:       r_cfg.prop_gain       <= i_cfg_data[15:0];
                REG_INTEG_GAIN:      r_cfg.integ_gain      <= i_cfg_data[15:0];
                REG_DERIV_GAIN:      r_cfg.deriv_gain      <= i_cfg_data[15:0];
                REG_ERROR_LIMIT:     r_cfg.error_limit     <= i_cfg_data[14:0];
                REG_INTEGRAL_LIMIT:  r_cfg.integral_limit  <= i_cfg_data[30:0];
                REG_PROP_OUT_LIMIT:  r_cfg.prop_out_limit  <= i_cfg_data[14:0];
                REG_INTEG_OUT_LIMIT: r_cfg.integ_out_limit <= i_cfg_data[14:0];
                REG_TOTAL_OUT_LIMIT: r_cfg.total_out_limit <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/cpid_ctrl.sv
// ----------------------------------------------------------------------------
// cpid_ctrl
// Sequencer of one control step: issues datapath operations and multiplier
// operand selections one cycle at a time; ST_SUM waits for a free output.
// ----------------------------------------------------------------------------
module cpid_ctrl
    import cpid_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_ERR;
            ST_ERR:   n_state = i_status.clear ? ST_SUM : ST_STEP;
            ST_STEP:  n_state = ST_ACC;
            ST_ACC:   n_state = ST_PROP;
            ST_PROP:  n_state = ST_IHI;
            ST_IHI:   n_state = ST_ILO;
            ST_ILO:   n_state = ST_DERIV;
            ST_DERIV: n_state = ST_SUM;
            ST_SUM:   if (i_status.out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op      = OP_HOLD;
        o_cmd.mul_sel = MUL_STEP;
        o_stall       = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.op = OP_LOAD;
                o_stall  = 1'b0;
            end
            ST_ERR:   o_cmd.op = OP_ERR;
            ST_STEP: begin
                o_cmd.op      = OP_STEP;
                o_cmd.mul_sel = MUL_STEP;
            end
            ST_ACC: begin
                o_cmd.op      = OP_ACC;
                o_cmd.mul_sel = MUL_PROP;
            end
            ST_PROP: begin
                o_cmd.op      = OP_PROP;
                o_cmd.mul_sel = MUL_IHI;
            end
            ST_IHI: begin
                o_cmd.op      = OP_IHI;
                o_cmd.mul_sel = MUL_ILO;
            end
            ST_ILO: begin
                o_cmd.op      = OP_ILO;
                o_cmd.mul_sel = MUL_DERIV;
            end
            ST_DERIV: o_cmd.op = OP_DERIV;
            ST_SUM:   o_cmd.op = i_status.out_free ? OP_SUM : OP_HOLD;
            default:  o_cmd.op = OP_HOLD;
        endcase
    end

endmodule

### src/cpid_dp.sv
// ----------------------------------------------------------------------------
// cpid_dp
// Datapath: one shared 17 x 18 signed multiplier, the controller history,
// term registers and the output word register.
// ----------------------------------------------------------------------------
module cpid_dp
    import cpid_pkg::*;
#(
    parameter int DERIV_OUT_LIMIT = DERIV_OUT_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_in_word   i_in_word,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_word  o_out_word
);

    localparam logic [30:0] DERIV_LIM = 31'(DERIV_OUT_LIMIT);

    // Controller history.
    logic signed [31:0] r_integ;
    logic signed [15:0] r_prev;

    // Working registers of the current step.
    logic               r_cmd;
    logic signed [15:0] r_err_in;
    logic signed [16:0] r_e;
    logic signed [17:0] r_diff;
    logic signed [34:0] r_prod;
    logic signed [32:0] r_ihi;
    logic signed [15:0] r_p;
    logic signed [15:0] r_i;
    logic signed [15:0] r_d;
    logic               r_out_valid;
    t_out_word          r_out;

    logic signed [16:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [34:0] product;
    logic signed [33:0] e_cl;
    logic signed [33:0] acc_cl;
    logic signed [33:0] p_cl;
    logic signed [48:0] i_full;
    logic signed [33:0] i_cl;
    logic signed [33:0] d_cl;
    logic signed [17:0] sum;
    logic signed [33:0] sum_cl;
    logic               out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_status.clear    = r_cmd;
    assign o_status.out_free = out_free;

    always_comb begin
        mul_a = signed'({1'b0, i_cfg.prop_gain});
        mul_b = 18'(r_e);
        unique case (i_cmd.mul_sel)
            MUL_STEP: begin
                mul_a = ERR_STEP_Q16;
                mul_b = 18'(r_e);
            end
            MUL_PROP: begin
                mul_a = signed'({1'b0, i_cfg.prop_gain});
                mul_b = 18'(r_e);
            end
            MUL_IHI: begin
                mul_a = signed'({1'b0, i_cfg.integ_gain});
                mul_b = 18'(signed'(r_integ[31:16]));
            end
            MUL_ILO: begin
                mul_a = signed'({1'b0, i_cfg.integ_gain});
                mul_b = signed'({2'b00, r_integ[15:0]});
            end
            MUL_DERIV: begin
                mul_a = signed'({1'b0, i_cfg.deriv_gain});
                mul_b = r_diff;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = 35'(mul_a) * 35'(mul_b);

    assign e_cl   = f_clamp(34'(r_err_in), {16'b0, i_cfg.error_limit});
    assign acc_cl = f_clamp(34'(r_integ) + 34'(r_prod), i_cfg.integral_limit);
    assign p_cl   = f_clamp(34'(signed'(r_prod[34:16])), {16'b0, i_cfg.prop_out_limit});
    // Integral term: the product was formed from the upper and lower halves
    // of the accumulator, so the two partial products are joined here.
    assign i_full = (49'(r_ihi) <<< 16) + signed'({16'b0, r_prod[32:0]});
    assign i_cl   = f_clamp(34'(signed'(i_full[48:32])), {16'b0, i_cfg.integ_out_limit});
    assign d_cl   = f_clamp(34'(signed'(r_prod[34:16])), DERIV_LIM);
    assign sum    = 18'(r_p) + 18'(r_i) + 18'(r_d);
    assign sum_cl = f_clamp(34'(sum), {16'b0, i_cfg.total_out_limit});

    always_ff @(posedge i_clk) begin
        r_prod <= product;
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_cmd    <= i_in_word.command;
                r_err_in <= i_in_word.error_in;
            end
            OP_ERR: begin
                r_e <= e_cl[16:0];
                r_p <= '0;
                r_i <= '0;
                r_d <= '0;
            end
            OP_STEP:  r_diff <= 18'(r_e) - 18'(r_prev);
            OP_IHI:   r_ihi  <= r_prod[32:0];
            OP_PROP:  r_p    <= p_cl[15:0];
            OP_ILO:   r_i    <= i_cl[15:0];
            OP_DERIV: r_d    <= d_cl[15:0];
            OP_SUM: begin
                r_out.drive      <= sum_cl[15:0];
                r_out.prop_term  <= r_p;
                r_out.integ_term <= r_i;
                r_out.deriv_term <= r_d;
            end
            OP_HOLD, OP_ACC: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ     <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_ERR && r_cmd) begin
                r_integ <= '0;
                r_prev  <= '0;
            end else if (i_cmd.op == OP_ACC) begin
                r_integ <= acc_cl[31:0];
                r_prev  <= r_e[15:0];
            end
            if (i_cmd.op == OP_SUM) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_word = r_out;

endmodule

### src/clamped_pid_controller.sv
// ----------------------------------------------------------------------------
// clamped_pid_controller
// Positional PID controller with a symmetric clamp on the error, the integral,
// each term and the summed drive.
//
//   Channel   Handshake           Payload            Direction
//   input     i_valid / o_stall   i_in_word          into the block
//   output    o_valid / i_stall   o_out_word         out of the block
//   config    i_cfg_wr_en         i_cfg_index/data   into the block
//
// A compute word steps through ST_ERR, ST_STEP, ST_ACC, ST_PROP, ST_IHI,
// ST_ILO and ST_DERIV to ST_SUM, which writes the result register; a clear
// word goes from ST_ERR to ST_SUM. ST_IDLE then takes the next word. The
// sequence is set by the single shared multiplier, used five times per step,
// with the integral product split in two 16-bit halves. Reset is synchronous;
// the history and the output valid clear at once. While a result waits under
// stall, the next word is accepted and worked until its result is ready.
// ----------------------------------------------------------------------------
module clamped_pid_controller
    import cpid_pkg::*;
#(
    parameter int DERIV_OUT_LIMIT = DERIV_OUT_LIMIT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_word              i_in_word,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       cfg;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    cpid_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cpid_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    cpid_dp #(
        .DERIV_OUT_LIMIT (DERIV_OUT_LIMIT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_word  (i_in_word),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_word (o_out_word)
    );

endmodule

### src/cpid_checker.sv
// ----------------------------------------------------------------------------
// cpid_checker
// Port-level checks of the clamped PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module cpid_checker
    import cpid_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input t_out_word             o_out_word
);

    // A waiting result word holds still under stall.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_word))
        else $error("result word changed under stall");

    // An accepted word keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted again without a step in between");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Symmetric clamps never yield the most negative code.
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out_word.drive != 16'sh8000 && o_out_word.prop_term != 16'sh8000
                 && o_out_word.integ_term != 16'sh8000 && o_out_word.deriv_term != 16'sh8000)
        else $error("result outside the symmetric range");

endmodule

bind clamped_pid_controller cpid_checker u_cpid_checker (.*);

### tb/tb_clamped_pid_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clamped_pid_controller
// Self-checking bench for the clamped PID controller. Words are fed through
// the valid/stall handshake from a queue, each accepted word is run through a
// behavioral copy of the controller, and every result word is compared field
// by field with the oldest prediction. The run steps through several register
// settings, idling patterns and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_clamped_pid_controller;
    import cpid_pkg::*;

    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;
    localparam int   PHASE_WORDS = 150;
    localparam int   RAND_PHASES = 11;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_in_word              i_in_word = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    clamped_pid_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_word   (i_in_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_word  (o_out_word),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Controller registers and history as the bench believes them to be.
    bit [15:0] kp = '0, ki = '0, kd = '0;
    bit [14:0] lim_err = 15'h7FFF, lim_p = 15'h7FFF, lim_i = 15'h7FFF, lim_total = 15'h7FFF;
    bit [30:0] lim_integ = 31'h7FFF_FFFF;
    int        hist_integ = 0;
    int        hist_err = 0;

    t_in_word  error_samples[$];
    t_out_word pending_drives[$];
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    logic      long_hold = 1'b0;
    int        err_count = 0;

    function automatic longint clamp_to(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // One controller step; updates the integral and the previous error.
    function automatic t_out_word compute_drive(t_in_word w);
        longint    e, acc, p, it, d, t;
        t_out_word r;
        r = '0;
        if (w.command == CMD_CLEAR) begin
            hist_integ = 0;
            hist_err = 0;
            return r;
        end
        e   = clamp_to(longint'($signed(w.error_in)), longint'(lim_err));
        acc = clamp_to(longint'(hist_integ) + e * 131, longint'(lim_integ));
        hist_integ = int'(acc);
        p  = clamp_to((longint'(kp) * e) >>> 16, longint'(lim_p));
        it = clamp_to((longint'(ki) * acc) >>> 32, longint'(lim_i));
        d  = clamp_to((longint'(kd) * (e - longint'(hist_err))) >>> 16,
                      longint'(DERIV_OUT_LIMIT_DEF));
        hist_err = int'(e);
        t  = clamp_to(p + it + d, longint'(lim_total));
        r.drive      = 16'(t);
        r.prop_term  = 16'(p);
        r.integ_term = 16'(it);
        r.deriv_term = 16'(d);
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        err_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("%s got %0d expected %0d", name,
                                    $signed(got), $signed(want)));
        end
    endtask

    // Sender: offers queued words, holds a word steady while it is stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                pending_drives.push_back(compute_drive(i_in_word));
            end
            if (!i_valid || !o_stall) begin
                if (error_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_word <= error_samples.pop_front();
                    i_valid   <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every accepted result word and decides the next stall.
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_drives.size() == 0) begin
                    note_mismatch("result word with no prediction waiting");
                end else begin
                    want = pending_drives.pop_front();
                    check_field("drive", o_out_word.drive, want.drive);
                    check_field("prop_term", o_out_word.prop_term, want.prop_term);
                    check_field("integ_term", o_out_word.integ_term, want.integ_term);
                    check_field("deriv_term", o_out_word.deriv_term, want.deriv_term);
                end
            end
            i_stall <= long_hold || ($urandom_range(99) < stall_pct);
        end
    end

    // Register writes land on one clock edge; the block is idle meanwhile.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
        logic [30:0] mask;
        logic [30:0] data;
        case (idx)
            REG_PROP_GAIN, REG_INTEG_GAIN, REG_DERIV_GAIN: mask = 31'h0000_FFFF;
            REG_INTEGRAL_LIMIT:                            mask = 31'h7FFF_FFFF;
            default:                                       mask = 31'h0000_7FFF;
        endcase
        // Bits above the register width carry noise and must be dropped.
        data = (31'($urandom()) & ~mask) | (31'(val) & mask);
        case (idx)
            REG_PROP_GAIN:       kp = data[15:0];
            REG_INTEG_GAIN:      ki = data[15:0];
            REG_DERIV_GAIN:      kd = data[15:0];
            REG_ERROR_LIMIT:     lim_err = data[14:0];
            REG_INTEGRAL_LIMIT:  lim_integ = data[30:0];
            REG_PROP_OUT_LIMIT:  lim_p = data[14:0];
            REG_INTEG_OUT_LIMIT: lim_i = data[14:0];
            default:             lim_total = data[14:0];
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_all(input longint unsigned g0, g1, g2, e_lim, int_lim,
                           p_lim, i_lim, t_lim);
        set_reg(REG_PROP_GAIN, g0);
        set_reg(REG_INTEG_GAIN, g1);
        set_reg(REG_DERIV_GAIN, g2);
        set_reg(REG_ERROR_LIMIT, e_lim);
        set_reg(REG_INTEGRAL_LIMIT, int_lim);
        set_reg(REG_PROP_OUT_LIMIT, p_lim);
        set_reg(REG_INTEG_OUT_LIMIT, i_lim);
        set_reg(REG_TOTAL_OUT_LIMIT, t_lim);
    endtask

    task automatic queue_word(input logic cmd, input logic [15:0] err);
        t_in_word w;
        w.command  = cmd;
        w.error_in = err;
        @(negedge i_clk);
        error_samples.push_back(w);
    endtask

    task automatic drain;
        while (error_samples.size() != 0 || pending_drives.size() != 0 || i_valid) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);
    endtask

    function automatic longint unsigned pick_gain();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 16'hFFFF;
            2:       return $urandom_range(1024);
            default: return $urandom_range(16'hFFFF);
        endcase
    endfunction

    function automatic longint unsigned pick_limit15();
        case ($urandom_range(4))
            0:       return 0;
            1:       return 15'h7FFF;
            2:       return $urandom_range(600);
            default: return $urandom_range(15'h7FFF);
        endcase
    endfunction

    function automatic longint unsigned pick_integ_limit();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 31'h7FFF_FFFF;
            2:       return $urandom_range(1 << 24);
            default: return $urandom() & 32'h7FFF_FFFF;
        endcase
    endfunction

    initial begin
        int   drift;
        logic [15:0] err;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Reset settings: all gains zero, so only zeros come back.
        queue_word(CMD_STEP, 16'h7FFF);
        queue_word(CMD_STEP, 16'h8000);
        queue_word(CMD_CLEAR, 16'h1234);
        drain();

        // Full gains, open limits: extremes, a derivative swing and a clear.
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 31'h7FFF_FFFF,
                15'h7FFF, 15'h7FFF, 15'h7FFF);
        queue_word(CMD_STEP, 16'h7FFF);
        queue_word(CMD_STEP, 16'h8000);
        queue_word(CMD_STEP, 16'h0000);
        queue_word(CMD_STEP, 16'hFFFF);
        queue_word(CMD_STEP, 16'h0001);
        queue_word(CMD_STEP, 16'h5555);
        queue_word(CMD_STEP, 16'hAAAA);
        queue_word(CMD_CLEAR, 16'hFFFF);
        queue_word(CMD_STEP, 16'h0100);
        repeat (8) queue_word(CMD_STEP, 16'h7FFF);
        drain();

        // Lowering the integral limit clamps the stored integral on the next step.
        set_reg(REG_INTEGRAL_LIMIT, 1 << 20);
        queue_word(CMD_STEP, 16'h0000);
        drain();

        // Zero limits force every clamped value but the derivative term to zero.
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0);
        queue_word(CMD_STEP, 16'h7FFF);
        queue_word(CMD_STEP, 16'h8000);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0) begin
                set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 31'h7FFF_FFFF,
                        15'h7FFF, 15'h7FFF, 15'h7FFF);
            end else begin
                set_all(pick_gain(), pick_gain(), pick_gain(), pick_limit15(),
                        pick_integ_limit(), pick_limit15(), pick_limit15(),
                        pick_limit15());
            end
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 63; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 63; end
                default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            drift = 1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(15) == 0) begin
                    drift = -drift;
                end
                case ($urandom_range(9))
                    0:       err = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                    1, 2, 3: err = 16'($urandom());
                    4, 5, 6: err = 16'($signed(32'($urandom_range(2048))) - 1024);
                    default: err = 16'(drift * int'($urandom_range(32767)));
                endcase
                if ($urandom_range(9) == 0) begin
                    queue_word(CMD_CLEAR, err);
                end else begin
                    queue_word(CMD_STEP, err);
                end
            end
            // Long receiver hold-off while the sender keeps offering words.
            if (ph == 4) begin
                @(negedge i_clk);
                long_hold = 1'b1;
                repeat (400) @(negedge i_clk);
                long_hold = 1'b0;
            end
            drain();
        end

        if (err_count == 0 && pending_drives.size() == 0) begin
            $display("clamped_pid_controller test passed");
        end else begin
            $display("clamped_pid_controller test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("clamped_pid_controller test failed");
        $finish;
    end

endmodule
